// ----- rtl/framed_message_ring_buffer_top_defines.svh -----
// Assertion macros used by the back part of the ring buffer RTL.
`ifndef FRAMED_MESSAGE_RING_BUFFER_TOP_DEFINES_SVH
`define FRAMED_MESSAGE_RING_BUFFER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FMRB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FMRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/fmrb_pkg.sv -----
// Package with shared constants and types of the framed message ring buffer.
`default_nettype none
package fmrb_pkg;
	localparam int RING_BYTES_DEF  = 256;
	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int HEADER_BYTES    = 4;
	localparam logic [7:0] MARKER_RESET = 8'd170;

	localparam logic [1:0] KIND_COMMIT = 2'd0;
	localparam logic [1:0] KIND_DROP   = 2'd1;
	localparam logic [1:0] KIND_BYTE   = 2'd2;
	localparam logic [1:0] KIND_EMPTY  = 2'd3;

	localparam logic [0:0] ACT_PUSH = 1'b0;
	localparam logic [0:0] ACT_PULL = 1'b1;

	// One queued command from the front part to the back part.
	typedef struct packed {
		logic        pull;
		logic [7:0]  data;
		logic        last;
		logic [15:0] addr;
		logic        blk;
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/fmrb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fmrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/fmrb_front.sv -----
// Front part: accepts start commands into a two-entry queue.
`default_nettype none
module fmrb_front import fmrb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t in_cmd,
	output logic      busy,
	output logic      q_valid,
	output cmd_t      q_cmd,
	input  wire logic q_pop
);
	cmd_t       ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/fmrb_back.sv -----
// Back part: executes push and pull commands against the byte ring.
`default_nettype none
module fmrb_back import fmrb_pkg::*; #(
	parameter int RING_BYTES  = RING_BYTES_DEF,
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  marker,
	input  wire logic        q_valid,
	input  wire cmd_t        q_cmd,
	output logic             q_pop,
	output logic             strobe,
	output logic [1:0]       kind,
	output logic [15:0]      out_address,
	output logic             out_block,
	output logic [7:0]       out_byte,
	output logic [6:0]       out_length,
	output logic             out_last,
	output logic             not_empty
);
`include "framed_message_ring_buffer_top_defines.svh"
	localparam int AW = $clog2(RING_BYTES);
	localparam int CW = AW + 1;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_HW1   = 12'b000000000010,
		ST_HW2   = 12'b000000000100,
		ST_HW3   = 12'b000000001000,
		ST_HW4   = 12'b000000010000,
		ST_SCAN  = 12'b000000100000,
		ST_RD0   = 12'b000001000000,
		ST_RD1   = 12'b000010000000,
		ST_RD2   = 12'b000100000000,
		ST_RD3   = 12'b001000000000,
		ST_CHK   = 12'b010000000000,
		ST_DRAIN = 12'b100000000000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] rp_q, wp_q;
	logic [6:0]    ocnt_q;
	logic          big_q;
	logic          hasf_q;
	logic [6:0]    len_q;
	logic          blk_q;
	logic [7:0]    alo_q, ahi_q;
	logic [15:0]   addr_q;
	logic [6:0]    idx_q;
	logic          dvalid_q;
	logic [AW-1:0] scan_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	logic [AW-1:0] used;
	logic [CW-1:0] freeb;
	logic [CW-1:0] need_byte, need_commit;
	logic          byte_ok, commit_ok;

	logic          push_wr;
	logic [6:0]    ocnt_n;
	logic          big_n;

	fmrb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Space checks for the open message.
	always_comb begin
		used        = wp_q - rp_q;
		freeb       = CW'(RING_BYTES) - CW'(used);
		need_byte   = CW'(HEADER_BYTES + 3) + CW'(ocnt_q);
		need_commit = CW'(HEADER_BYTES + 2) + CW'(ocnt_n);
		byte_ok     = (ocnt_q < 7'(MAX_PAYLOAD)) && (need_byte <= freeb);
		commit_ok   = (ocnt_n != 7'd0) && (freeb >= need_commit);
	end

	assign push_wr = (state_q == ST_IDLE) && q_valid && !q_pop && !q_cmd.pull &&
		!big_q && byte_ok;
	assign ocnt_n  = push_wr ? ocnt_q + 7'd1 : ocnt_q;
	assign big_n   = big_q || (!big_q && !byte_ok);

	// Header checks on the candidate frame at the read pointer.
	logic [CW-1:0] used_w;
	logic          hdr_ok;
	assign used_w = CW'(used);
	assign hdr_ok = (len_q != 7'd0) && (len_q <= 7'(MAX_PAYLOAD)) &&
		(CW'(HEADER_BYTES) + CW'(len_q) <= used_w);

	// Memory port selection.
	always_comb begin
		we    = 1'b0;
		waddr = wp_q + AW'(HEADER_BYTES) + AW'(ocnt_q);
		wdata = q_cmd.data;
		raddr = rp_q;
		unique case (state_q)
			ST_IDLE: begin
				we = push_wr;
			end
			ST_HW1: begin
				we    = 1'b1;
				waddr = wp_q;
				wdata = marker;
			end
			ST_HW2: begin
				we    = 1'b1;
				waddr = wp_q + AW'(1);
				wdata = {blk_q, len_q};
			end
			ST_HW3: begin
				we    = 1'b1;
				waddr = wp_q + AW'(2);
				wdata = addr_q[7:0];
			end
			ST_HW4: begin
				we    = 1'b1;
				waddr = wp_q + AW'(3);
				wdata = addr_q[15:8];
			end
			ST_SCAN: raddr = rp_q;
			ST_RD0:  raddr = rp_q + AW'(1);
			ST_RD1:  raddr = rp_q + AW'(2);
			ST_RD2:  raddr = rp_q + AW'(3);
			ST_RD3:  raddr = rp_q + AW'(HEADER_BYTES);
			ST_CHK:  raddr = rp_q + AW'(HEADER_BYTES);
			ST_DRAIN: raddr = scan_q;
			default: raddr = rp_q;
		endcase
	end

	logic [AW-1:0] nrp;
	assign nrp = rp_q + AW'(HEADER_BYTES) + AW'(len_q);

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			ocnt_q      <= '0;
			big_q       <= 1'b0;
			hasf_q      <= 1'b0;
			strobe      <= 1'b0;
			q_pop       <= 1'b0;
			dvalid_q    <= 1'b0;
			len_q       <= '0;
			blk_q       <= 1'b0;
			alo_q       <= '0;
			ahi_q       <= '0;
			addr_q      <= '0;
			idx_q       <= '0;
			scan_q      <= '0;
			kind        <= KIND_COMMIT;
			out_address <= '0;
			out_block   <= 1'b0;
			out_byte    <= '0;
			out_length  <= '0;
			out_last    <= 1'b0;
			not_empty   <= 1'b0;
		end else begin
			strobe   <= 1'b0;
			q_pop    <= 1'b0;
			dvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && !q_pop) begin
						if (!q_cmd.pull) begin
							ocnt_q <= ocnt_n;
							big_q  <= big_n;
							if (!q_cmd.last) begin
								q_pop <= 1'b1;
							end else if (!big_n && commit_ok) begin
								len_q   <= ocnt_n;
								blk_q   <= q_cmd.blk;
								addr_q  <= q_cmd.addr;
								state_q <= ST_HW1;
							end else begin
								ocnt_q <= '0;
								big_q  <= 1'b0;
								q_pop  <= 1'b1;
								strobe <= 1'b1;
								kind   <= KIND_DROP;
								out_address <= '0;
								out_block   <= 1'b0;
								out_byte    <= '0;
								out_length  <= '0;
								out_last    <= 1'b1;
								not_empty   <= hasf_q;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_HW1: state_q <= ST_HW2;
				ST_HW2: state_q <= ST_HW3;
				ST_HW3: state_q <= ST_HW4;
				ST_HW4: begin
					// Last header byte goes in this cycle; the frame commits.
					wp_q    <= wp_q + AW'(HEADER_BYTES) + AW'(len_q);
					hasf_q  <= 1'b1;
					ocnt_q  <= '0;
					big_q   <= 1'b0;
					q_pop   <= 1'b1;
					strobe  <= 1'b1;
					kind    <= KIND_COMMIT;
					out_address <= '0;
					out_block   <= 1'b0;
					out_byte    <= '0;
					out_length  <= '0;
					out_last    <= 1'b1;
					not_empty   <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (rp_q == wp_q) begin
						hasf_q  <= 1'b0;
						q_pop   <= 1'b1;
						strobe  <= 1'b1;
						kind    <= KIND_EMPTY;
						out_address <= '0;
						out_block   <= 1'b0;
						out_byte    <= '0;
						out_length  <= '0;
						out_last    <= 1'b1;
						not_empty   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					if (rdata == marker && used >= AW'(HEADER_BYTES + 1)) begin
						state_q <= ST_RD1;
					end else begin
						rp_q    <= rp_q + AW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_RD1: begin
					len_q   <= rdata[6:0];
					blk_q   <= rdata[7];
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					alo_q   <= rdata;
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					ahi_q   <= rdata;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hdr_ok) begin
						scan_q   <= rp_q + AW'(HEADER_BYTES + 1);
						idx_q    <= '0;
						dvalid_q <= 1'b1;
						rp_q     <= nrp;
						hasf_q   <= (nrp != wp_q);
						state_q  <= ST_DRAIN;
					end else begin
						rp_q    <= rp_q + AW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_DRAIN: begin
					if (dvalid_q || idx_q != 7'd0) begin
						strobe      <= 1'b1;
						kind        <= KIND_BYTE;
						out_address <= {ahi_q, alo_q};
						out_block   <= blk_q;
						out_byte    <= rdata;
						out_length  <= len_q;
						out_last    <= (idx_q + 7'd1 == len_q);
						not_empty   <= hasf_q;
						scan_q      <= scan_q + AW'(1);
						idx_q       <= idx_q + 7'd1;
						if (idx_q + 7'd1 == len_q) begin
							q_pop   <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FMRB_ASSERT_IMPL(a_one_pop, q_pop, !$isunknown(state_q))
	`FMRB_ASSERT_NEXT(a_pop_with_last, q_pop && strobe, state_q == ST_IDLE)
	`FMRB_ASSERT_IMPL(a_strobe_last, strobe && kind != KIND_BYTE, out_last)
endmodule
`default_nettype wire

// ----- rtl/framed_message_ring_buffer_top.sv -----
// Top level of the framed message ring buffer.
//  channel | direction | handshake
//  cmd     | in        | start && !busy
//  result  | out       | strobe, one cycle, no stall
//  config  | in        | APB write, pready always high
// A push byte that does not close its message is written while idle; a closing
// push then writes the header bytes in ST_HW1 to ST_HW4 and commits the frame.
// A pull skips bytes from the read pointer to a marker byte whose header passes
// its checks and drains that frame, or reports empty when it meets the write
// pointer. The ring memory has a single read port. Reset is asynchronous, low.
// Results cannot be stalled; busy rises when the command queue is full.
`default_nettype none
module framed_message_ring_buffer_top import fmrb_pkg::*; #(
	parameter int RING_BYTES  = RING_BYTES_DEF,
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] target_address,
	input  wire logic        target_block,
	output logic             strobe,
	output logic [1:0]       kind,
	output logic [15:0]      out_address,
	output logic             out_block,
	output logic [7:0]       out_byte,
	output logic [6:0]       out_length,
	output logic             out_last,
	output logic             not_empty,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [7:0] marker_q;
	cmd_t       in_cmd, q_cmd;
	logic       q_valid, q_pop;

	assign pready = 1'b1;
	assign prdata = {24'd0, marker_q};

	// Marker register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (psel && penable && pwrite && !paddr) begin
			marker_q <= pwdata[7:0];
		end
	end

	assign in_cmd = '{pull: action, data: data_byte, last: last_byte,
		addr: target_address, blk: target_block};

	fmrb_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_cmd(in_cmd), .busy(busy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	fmrb_back #(.RING_BYTES(RING_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk(clk), .arst_n(arst_n), .marker(marker_q), .q_valid(q_valid),
		.q_cmd(q_cmd), .q_pop(q_pop), .strobe(strobe), .kind(kind),
		.out_address(out_address), .out_block(out_block), .out_byte(out_byte),
		.out_length(out_length), .out_last(out_last), .not_empty(not_empty)
	);
endmodule
`default_nettype wire

// ----- tb/sv/framed_message_ring_buffer_top_tb.sv -----
// Self-checking testbench for the framed message ring buffer top level.
`timescale 1ns / 1ps
`default_nettype none
module framed_message_ring_buffer_top_tb;
	import fmrb_pkg::*;

	localparam int RING = 256;
	localparam int MAXPL = 64;
	localparam int CYCLE_LIMIT = 1500000;

	// Expected result of one transaction on the result side.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic        blk;
		logic [7:0]  data;
		logic [6:0]  len;
		logic        last;
		logic        ne;
	} frame_result_t;

	// One row of the directed table; chk set means the result is typed in.
	typedef struct {
		logic          act;
		logic [7:0]    data;
		logic          last;
		logic [15:0]   addr;
		logic          blk;
		logic          chk;
		frame_result_t res;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [7:0] data_byte;
	logic last_byte;
	logic [15:0] target_address;
	logic target_block;
	logic strobe;
	logic [1:0] kind;
	logic [15:0] out_address;
	logic out_block;
	logic [7:0] out_byte;
	logic [6:0] out_length;
	logic out_last;
	logic not_empty;
	logic psel;
	logic penable;
	logic pwrite;
	logic paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the ring and its pointers.
	logic [7:0] ring_shadow [RING];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned open_count;
	logic open_doomed;
	logic frames_left;
	logic [7:0] marker;

	frame_result_t pending_results[$];
	int errors;
	longint cycles;
	bit idle_enable;

	framed_message_ring_buffer_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned ring_used();
		return (wr_ptr + RING - rd_ptr) % RING;
	endfunction

	function automatic frame_result_t make_result(logic [1:0] k, logic [15:0] a, logic b,
			logic [7:0] d, logic [6:0] l, logic lst);
		frame_result_t r;
		r.kind = k;
		r.addr = a;
		r.blk = b;
		r.data = d;
		r.len = l;
		r.last = lst;
		r.ne = frames_left;
		return r;
	endfunction

	// Apply one push byte to the shadow state; queue a result when it closes a message.
	task automatic predict_push(logic [7:0] d, logic lst, logic [15:0] a, logic b);
		int unsigned free_bytes;
		logic [1:0] k;
		free_bytes = RING - ring_used();
		if (!open_doomed) begin
			if (open_count >= MAXPL || HEADER_BYTES + open_count + 3 > free_bytes)
				open_doomed = 1'b1;
			else begin
				ring_shadow[(wr_ptr + HEADER_BYTES + open_count) % RING] = d;
				open_count++;
			end
		end
		if (lst) begin
			if (!open_doomed && open_count > 0 && free_bytes >= HEADER_BYTES + open_count + 2) begin
				ring_shadow[wr_ptr] = marker;
				ring_shadow[(wr_ptr + 1) % RING] = {b, open_count[6:0]};
				ring_shadow[(wr_ptr + 2) % RING] = a[7:0];
				ring_shadow[(wr_ptr + 3) % RING] = a[15:8];
				wr_ptr = (wr_ptr + HEADER_BYTES + open_count) % RING;
				frames_left = 1'b1;
				k = KIND_COMMIT;
			end else
				k = KIND_DROP;
			open_count = 0;
			open_doomed = 1'b0;
			pending_results.push_back(make_result(k, '0, 1'b0, '0, '0, 1'b1));
		end
	endtask

	// Scan to the next well-formed frame and drain it, or report empty.
	task automatic predict_pull();
		int unsigned used;
		int unsigned flen;
		int unsigned base;
		logic [7:0] b1;
		logic [15:0] a;
		while (rd_ptr != wr_ptr) begin
			used = ring_used();
			if (ring_shadow[rd_ptr] == marker && used >= HEADER_BYTES + 1) begin
				b1 = ring_shadow[(rd_ptr + 1) % RING];
				flen = b1[6:0];
				if (flen >= 1 && flen <= MAXPL && HEADER_BYTES + flen <= used) begin
					a = {ring_shadow[(rd_ptr + 3) % RING], ring_shadow[(rd_ptr + 2) % RING]};
					base = rd_ptr + HEADER_BYTES;
					rd_ptr = (base + flen) % RING;
					frames_left = rd_ptr != wr_ptr;
					for (int i = 0; i < flen; i++)
						pending_results.push_back(make_result(KIND_BYTE, a, b1[7],
							ring_shadow[(base + i) % RING], flen[6:0], i + 1 == flen));
					return;
				end
			end
			rd_ptr = (rd_ptr + 1) % RING;
		end
		frames_left = 1'b0;
		pending_results.push_back(make_result(KIND_EMPTY, '0, 1'b0, '0, '0, 1'b1));
	endtask

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin
		frame_result_t exp_r;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d", kind);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, actual %0d", exp_r.kind, kind); errors++;
				end
				if (out_address !== exp_r.addr) begin
					$error("out_address: expected %0h, actual %0h", exp_r.addr, out_address);
					errors++;
				end
				if (out_block !== exp_r.blk) begin
					$error("out_block: expected %0d, actual %0d", exp_r.blk, out_block); errors++;
				end
				if (out_byte !== exp_r.data) begin
					$error("out_byte: expected %0h, actual %0h", exp_r.data, out_byte); errors++;
				end
				if (out_length !== exp_r.len) begin
					$error("out_length: expected %0d, actual %0d", exp_r.len, out_length);
					errors++;
				end
				if (out_last !== exp_r.last) begin
					$error("out_last: expected %0d, actual %0d", exp_r.last, out_last); errors++;
				end
				if (not_empty !== exp_r.ne) begin
					$error("not_empty: expected %0d, actual %0d", exp_r.ne, not_empty); errors++;
				end
			end
		end
	end

	// Send one command and update the prediction when it is accepted.
	// Start stays high after acceptance so that commands can follow back to back.
	task automatic send_item(logic act, logic [7:0] d, logic lst, logic [15:0] a, logic b);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		data_byte <= d;
		last_byte <= lst;
		target_address <= a;
		target_block <= b;
		do @(posedge clk); while (busy);
		if (act == ACT_PULL)
			predict_pull();
		else
			predict_push(d, lst, a, b);
	endtask

	// Wait for all expected results plus the longest scan time of a pull.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6 * RING + 100) @(posedge clk);
	endtask

	task automatic write_marker(logic [7:0] value);
		logic [7:0] readback;
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 1'b0;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		marker = value;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata[7:0];
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			$error("start_marker: expected %0h, actual %0h", value, readback);
			errors++;
		end
	endtask

	// Push one whole message with random content.
	task automatic push_message(int n, logic [15:0] a, logic b);
		for (int i = 0; i < n; i++)
			send_item(ACT_PUSH, 8'($urandom_range(0, 255)), i == n - 1, a, b);
	endtask

	directed_row_t directed_rows[$];

	function automatic directed_row_t row(logic act, logic [7:0] d, logic lst,
			logic [15:0] a, logic b, logic chk, logic [1:0] k, logic ne);
		directed_row_t r;
		r.act = act;
		r.data = d;
		r.last = lst;
		r.addr = a;
		r.blk = b;
		r.chk = chk;
		r.res = '{kind: k, addr: 16'd0, blk: 1'b0, data: 8'd0, len: 7'd0, last: 1'b1, ne: ne};
		return r;
	endfunction

	initial begin
		int n;
		frame_result_t typed;
		errors = 0;
		cycles = 0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		target_address = '0;
		target_block = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 1'b0;
		pwdata = '0;
		for (int i = 0; i < RING; i++) ring_shadow[i] = '0;
		rd_ptr = 0;
		wr_ptr = 0;
		open_count = 0;
		open_doomed = 1'b0;
		frames_left = 1'b0;
		marker = MARKER_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty pull after reset, extreme fields, single and two byte frames.
		directed_rows.push_back(row(ACT_PULL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1, KIND_EMPTY, 1'b0));
		directed_rows.push_back(row(ACT_PUSH, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, KIND_COMMIT, 1'b1));
		directed_rows.push_back(row(ACT_PUSH, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b1, KIND_COMMIT, 1'b1));
		directed_rows.push_back(row(ACT_PUSH, 8'hAA, 1'b0, 16'h1234, 1'b0, 1'b0, KIND_COMMIT, 1'b1));
		directed_rows.push_back(row(ACT_PUSH, 8'h55, 1'b1, 16'hA5C3, 1'b1, 1'b0, KIND_COMMIT, 1'b1));
		directed_rows.push_back(row(ACT_PULL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, KIND_BYTE, 1'b1));
		directed_rows.push_back(row(ACT_PULL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, KIND_BYTE, 1'b1));
		directed_rows.push_back(row(ACT_PULL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, KIND_BYTE, 1'b1));
		directed_rows.push_back(row(ACT_PULL, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1, KIND_EMPTY, 1'b0));
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].addr, directed_rows[i].blk);
			if (directed_rows[i].chk) begin
				// Typed rows cause one result, the newest expectation.
				typed = pending_results[pending_results.size() - 1];
				if (typed !== directed_rows[i].res) begin
					$error("directed row %0d: expected %h, actual %h", i,
						directed_rows[i].res, typed);
					errors++;
				end
			end
		end

		// Longest payload, an oversized message that is dropped, then more single
		// byte messages than the ring takes.
		push_message(MAXPL, 16'h8001, 1'b1);
		push_message(MAXPL + 1, 16'h7FFE, 1'b0);
		for (int i = 0; i < 40; i++)
			push_message(1, 16'(i), 1'(i));
		repeat (6) send_item(ACT_PULL, '0, 1'b0, '0, 1'b0);
		drain_results();

		// Changed marker: old frames get skipped byte by byte.
		push_message(3, 16'h0102, 1'b0);
		drain_results();
		write_marker(8'h00);
		push_message(2, 16'h0304, 1'b1);
		send_item(ACT_PULL, '0, 1'b0, '0, 1'b0);
		send_item(ACT_PULL, '0, 1'b0, '0, 1'b0);
		drain_results();
		write_marker(8'hFF);

		// Random traffic over several marker settings, small messages mostly.
		for (int phase = 0; phase < 4; phase++) begin
			for (int m = 0; m < 5; m++) begin
				if (phase == 3 && m == 2) idle_enable = 1'b0;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAXPL + 4)
							: $urandom_range(1, 4);
						push_message(n, 16'($urandom_range(0, 65535)),
							1'($urandom_range(0, 1)));
					end
					4: send_item(ACT_PUSH, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
					default: send_item(ACT_PULL, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
				endcase
			end
			if (phase < 3) begin
				drain_results();
				write_marker(phase == 0 ? 8'h00 : (phase == 1 ? MARKER_RESET : 8'h5A));
			end
		end
		repeat (8) send_item(ACT_PULL, '0, 1'b0, '0, 1'b0);

		drain_results();
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
